>>> rtl/grid_triangulation_index_generator_top_assert.svh
// Assertion macros for the grid triangulation index generator.
// Needs nothing else; included by the top level only.
`ifndef GRID_TRIANGULATION_INDEX_GENERATOR_TOP_ASSERT_SVH
`define GRID_TRIANGULATION_INDEX_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GTIG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gtig assertion failed");

// Next-cycle implication, disabled while in reset.
`define GTIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gtig assertion failed");

`endif

>>> rtl/gtig_pkg.sv
// Shared types and constants for the grid triangulation index generator.
// No dependencies; used by gtig_step and the top level.
`default_nettype none

package gtig_pkg;

    localparam int SIZE_W     = 9;   // grid side length and cell coordinates
    localparam int PROD_W     = 2 * SIZE_W;
    localparam int CNT_W      = 17;
    localparam int NODE_W     = 16;
    localparam int IDX_W      = 8;
    localparam int MASK_W     = 4;
    localparam int PAT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS    = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_PATTERN = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FAM_FIXED      = 2'd0,
        FAM_UNION_JACK = 2'd1,
        FAM_FWD_BACK   = 2'd2
    } family_t;

    typedef struct packed {
        logic [SIZE_W-1:0] m;       // clamped nodes per row
        logic [SIZE_W-1:0] n;       // clamped nodes per column
        family_t           family;
        logic              nw_base;
    } grid_cfg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] cell_row;
        logic [SIZE_W-1:0] cell_col;
        logic              half_select;
        logic              odd_row_pass;
        logic              second_column_sweep;
        logic [CNT_W-1:0]  triangle_count;
        logic              finished;
    } walk_state_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_c;
        logic [CNT_W-1:0]  element_number;
        logic [MASK_W-1:0] boundary_mask;
        logic [IDX_W-1:0]  side0_index;
        logic [IDX_W-1:0]  side1_index;
        logic [IDX_W-1:0]  side2_index;
        logic [IDX_W-1:0]  side3_index;
        logic              last_triangle;
    } triangle_t;

    function automatic family_t pattern_family(input logic [PAT_W-1:0] pattern);
        family_t fam;
        case (pattern[PAT_W-1:1])
            2'd1:    fam = FAM_UNION_JACK;
            2'd2:    fam = FAM_FWD_BACK;
            default: fam = FAM_FIXED;
        endcase
        return fam;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gtig_step.sv
// Combinational step of the walk: one triangle and the following walk state.
// Depends on gtig_pkg.
`default_nettype none

module gtig_step (
    input  var gtig_pkg::grid_cfg_t   cfg,
    input  var gtig_pkg::walk_state_t cur,
    input  wire logic                 restart,
    output gtig_pkg::walk_state_t     nxt,
    output gtig_pkg::triangle_t       tri_data,
    output logic                      emit
);

    localparam int SW = gtig_pkg::SIZE_W;
    localparam int PW = gtig_pkg::PROD_W;

    // Move to the next row of the current pass, or to the odd-row pass, or finish the walk.
    function automatic gtig_pkg::walk_state_t next_row_pass(
        input gtig_pkg::walk_state_t s,
        input logic [SW-1:0]         m,
        input logic [SW-1:0]         n
    );
        gtig_pkg::walk_state_t t;
        logic [SW:0]           row2;
        t    = s;
        row2 = {1'b0, s.cell_row} + (SW+1)'(2);
        t.cell_row = row2[SW-1:0];
        if (row2 > ({1'b0, n} - (SW+1)'(2))) begin
            if (!s.odd_row_pass && (n >= SW'(3))) begin
                t.odd_row_pass = 1'b1;
                t.cell_row     = SW'(1);
            end else begin
                t.finished = 1'b1;
            end
        end
        t.cell_col            = m - SW'(2);
        t.second_column_sweep = 1'b0;
        return t;
    endfunction

    gtig_pkg::walk_state_t st;
    gtig_pkg::walk_state_t adv;
    logic [SW-1:0]         m_minus2;
    logic [SW-1:0]         n_minus2;
    logic                  nw;
    logic [PW-1:0]         ul;
    logic [PW-1:0]         ll;
    logic [PW-1:0]         ur;
    logic [PW-1:0]         lr;
    logic                  at_right;
    logic                  at_top;
    logic                  at_left;
    logic                  at_bottom;
    logic [SW-1:0]         side1_full;
    logic [SW-1:0]         side2_full;

    always_comb
    begin
        m_minus2 = cfg.m - SW'(2);
        n_minus2 = cfg.n - SW'(2);

        st = cur;
        if (restart)
        begin
            st.cell_row            = '0;
            st.cell_col            = (cfg.family == gtig_pkg::FAM_FIXED) ? '0 : m_minus2;
            st.half_select         = 1'b0;
            st.odd_row_pass        = 1'b0;
            st.second_column_sweep = 1'b0;
            st.triangle_count      = '0;
            st.finished            = 1'b0;
        end
        emit = !st.finished;

        case (cfg.family)
            gtig_pkg::FAM_UNION_JACK: nw = cfg.nw_base ^ st.odd_row_pass ^ st.second_column_sweep;
            gtig_pkg::FAM_FWD_BACK:   nw = cfg.nw_base ^ st.odd_row_pass;
            default:                  nw = cfg.nw_base;
        endcase

        // corner node indices; UR sits one row (m nodes) above UL
        ul = PW'(st.cell_row) * PW'(cfg.m) + PW'(st.cell_col);
        ll = ul + PW'(1);
        ur = ul + PW'(cfg.m);
        lr = ur + PW'(1);

        at_right  = (st.cell_col == m_minus2);
        at_top    = (st.cell_row == n_minus2);
        at_left   = (st.cell_col == '0);
        at_bottom = (st.cell_row == '0);

        tri_data = '0;
        if (!nw)
        begin
            if (!st.half_select)
            begin
                tri_data.node_a           = ll[gtig_pkg::NODE_W-1:0];
                tri_data.node_b           = lr[gtig_pkg::NODE_W-1:0];
                tri_data.node_c           = ur[gtig_pkg::NODE_W-1:0];
                tri_data.boundary_mask[0] = at_right;
                tri_data.boundary_mask[1] = at_top;
            end
            else
            begin
                tri_data.node_a           = ll[gtig_pkg::NODE_W-1:0];
                tri_data.node_b           = ur[gtig_pkg::NODE_W-1:0];
                tri_data.node_c           = ul[gtig_pkg::NODE_W-1:0];
                tri_data.boundary_mask[2] = at_left;
                tri_data.boundary_mask[3] = at_bottom;
            end
        end
        else
        begin
            if (!st.half_select)
            begin
                tri_data.node_a           = ll[gtig_pkg::NODE_W-1:0];
                tri_data.node_b           = lr[gtig_pkg::NODE_W-1:0];
                tri_data.node_c           = ul[gtig_pkg::NODE_W-1:0];
                tri_data.boundary_mask[0] = at_right;
                tri_data.boundary_mask[3] = at_bottom;
            end
            else
            begin
                tri_data.node_a           = lr[gtig_pkg::NODE_W-1:0];
                tri_data.node_b           = ur[gtig_pkg::NODE_W-1:0];
                tri_data.node_c           = ul[gtig_pkg::NODE_W-1:0];
                tri_data.boundary_mask[2] = at_left;
                tri_data.boundary_mask[1] = at_top;
            end
        end

        side1_full = m_minus2 - st.cell_col;
        side2_full = n_minus2 - st.cell_row;
        tri_data.element_number = st.triangle_count;
        tri_data.side0_index = tri_data.boundary_mask[0] ?
                               st.cell_row[gtig_pkg::IDX_W-1:0] : '0;
        tri_data.side1_index = tri_data.boundary_mask[1] ?
                               side1_full[gtig_pkg::IDX_W-1:0] : '0;
        tri_data.side2_index = tri_data.boundary_mask[2] ?
                               side2_full[gtig_pkg::IDX_W-1:0] : '0;
        tri_data.side3_index = tri_data.boundary_mask[3] ?
                               st.cell_col[gtig_pkg::IDX_W-1:0] : '0;

        // advance past this triangle
        adv = st;
        adv.triangle_count = st.triangle_count + gtig_pkg::CNT_W'(1);
        if (!st.half_select)
        begin
            adv.half_select = 1'b1;
        end
        else
        begin
            adv.half_select = 1'b0;
            case (cfg.family)
                gtig_pkg::FAM_FWD_BACK:
                begin
                    if (st.cell_col != '0)
                        adv.cell_col = st.cell_col - SW'(1);
                    else
                        adv = next_row_pass(adv, cfg.m, cfg.n);
                end
                gtig_pkg::FAM_UNION_JACK:
                begin
                    if (st.cell_col >= SW'(2))
                        adv.cell_col = st.cell_col - SW'(2);
                    else if (!st.second_column_sweep && (cfg.m >= SW'(3)))
                    begin
                        adv.second_column_sweep = 1'b1;
                        adv.cell_col            = cfg.m - SW'(3);
                    end
                    else
                        adv = next_row_pass(adv, cfg.m, cfg.n);
                end
                default:
                begin
                    if (at_right)
                    begin
                        adv.cell_col = '0;
                        adv.cell_row = st.cell_row + SW'(1);
                        if (at_top)
                            adv.finished = 1'b1;
                    end
                    else
                        adv.cell_col = st.cell_col + SW'(1);
                end
            endcase
        end
        tri_data.last_triangle = adv.finished;

        nxt = emit ? adv : st;
    end

endmodule

`default_nettype wire

>>> rtl/grid_triangulation_index_generator_top.sv
// Grid triangulation index generator, top level.
// Depends on gtig_pkg, gtig_step and grid_triangulation_index_generator_top_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / restart): each transaction asks for one
//   triangle. restart = 1 starts the walk over and returns the first triangle;
//   restart = 0 returns the next one. After the last triangle of the layer an
//   advance yields no result transaction.
//   Output channel (out_valid / out_stall / fields): one triangle per result.
//   The result is registered at the edge that accepts the request. Throughput is
//   one triangle per cycle while the receiver does not stall; the cell index
//   multiply and walk update sit in the single stage between the walk registers
//   and the result register.
//   When the receiver stalls, the result register holds and in_stall rises; a request
//   is still taken in the cycle the held result leaves. Config port (cfg_we / cfg_index /
//   cfg_data): 0 cols, 1 rows, 2 pattern. A write to any of these makes the next request
//   act as a restart. The user makes writes only while idle; the block does not enforce it.
//   Reset: cols = rows = 2, pattern 0, walk at the first triangle, output empty.
`default_nettype none

`include "grid_triangulation_index_generator_top_assert.svh"

module grid_triangulation_index_generator_top #(
    parameter int unsigned MAX_NODES_PER_SIDE = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [gtig_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gtig_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                restart,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [gtig_pkg::NODE_W-1:0]              node_a,
    output logic [gtig_pkg::NODE_W-1:0]              node_b,
    output logic [gtig_pkg::NODE_W-1:0]              node_c,
    output logic [gtig_pkg::CNT_W-1:0]               element_number,
    output logic [gtig_pkg::MASK_W-1:0]              boundary_mask,
    output logic [gtig_pkg::IDX_W-1:0]               side0_index,
    output logic [gtig_pkg::IDX_W-1:0]               side1_index,
    output logic [gtig_pkg::IDX_W-1:0]               side2_index,
    output logic [gtig_pkg::IDX_W-1:0]               side3_index,
    output logic                                     last_triangle
);

    localparam int SW = gtig_pkg::SIZE_W;
    localparam int unsigned SideFieldMax = (1 << SW) - 1;
    localparam int unsigned SideClamp    =
        (MAX_NODES_PER_SIDE > SideFieldMax) ? SideFieldMax : MAX_NODES_PER_SIDE;
    localparam logic [SW-1:0] MaxSide    = SW'(SideClamp);

    logic [SW-1:0]                cols_reg;
    logic [SW-1:0]                rows_reg;
    logic [gtig_pkg::PAT_W-1:0]   pattern_reg;
    logic                         pend_restart_reg;
    logic                         pend_restart_next;
    gtig_pkg::walk_state_t        walk_reg;
    gtig_pkg::walk_state_t        walk_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    gtig_pkg::triangle_t          tri_reg;

    gtig_pkg::grid_cfg_t          grid_cfg;
    gtig_pkg::walk_state_t        step_nxt;
    gtig_pkg::triangle_t          step_tri;
    logic                         step_emit;
    logic                         accept;
    logic                         cfg_hit;

    // clamp sizes into the legal range
    always_comb
    begin
        if (cols_reg < SW'(2))
            grid_cfg.m = SW'(2);
        else if (cols_reg > MaxSide)
            grid_cfg.m = MaxSide;
        else
            grid_cfg.m = cols_reg;

        if (rows_reg < SW'(2))
            grid_cfg.n = SW'(2);
        else if (rows_reg > MaxSide)
            grid_cfg.n = MaxSide;
        else
            grid_cfg.n = rows_reg;

        grid_cfg.family  = gtig_pkg::pattern_family(pattern_reg);
        grid_cfg.nw_base = pattern_reg[0];
    end

    gtig_step u_step (
        .cfg      (grid_cfg),
        .cur      (walk_reg),
        .restart  (restart | pend_restart_reg),
        .nxt      (step_nxt),
        .tri_data (step_tri),
        .emit     (step_emit)
    );

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        case (cfg_index)
            gtig_pkg::CFG_COLS,
            gtig_pkg::CFG_ROWS,
            gtig_pkg::CFG_PATTERN: cfg_hit = cfg_we;
            default:               cfg_hit = 1'b0;
        endcase

        if (cfg_hit)
            pend_restart_next = 1'b1;
        else if (accept)
            pend_restart_next = 1'b0;
        else
            pend_restart_next = pend_restart_reg;

        walk_next = accept ? step_nxt : walk_reg;

        if (accept)
            out_valid_next = step_emit;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg         <= SW'(2);
            rows_reg         <= SW'(2);
            pattern_reg      <= '0;
            pend_restart_reg <= 1'b0;
            walk_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gtig_pkg::CFG_COLS:    cols_reg    <= cfg_data[SW-1:0];
                    gtig_pkg::CFG_ROWS:    rows_reg    <= cfg_data[SW-1:0];
                    gtig_pkg::CFG_PATTERN: pattern_reg <= cfg_data[gtig_pkg::PAT_W-1:0];
                    default:               ;
                endcase
            end
            pend_restart_reg <= pend_restart_next;
            walk_reg         <= walk_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step_emit)
            tri_reg <= step_tri;
    end

    assign out_valid      = out_valid_reg;
    assign node_a         = tri_reg.node_a;
    assign node_b         = tri_reg.node_b;
    assign node_c         = tri_reg.node_c;
    assign element_number = tri_reg.element_number;
    assign boundary_mask  = tri_reg.boundary_mask;
    assign side0_index    = tri_reg.side0_index;
    assign side1_index    = tri_reg.side1_index;
    assign side2_index    = tri_reg.side2_index;
    assign side3_index    = tri_reg.side3_index;
    assign last_triangle  = tri_reg.last_triangle;

    // an advance past the end produces nothing
    `GTIG_ASSERT_NEXT(a_no_result_after_end, clk, rst_n,
        accept && walk_reg.finished && !restart && !pend_restart_reg, !out_valid)
    // a restart always yields triangle zero
    `GTIG_ASSERT_NEXT(a_restart_first, clk, rst_n,
        accept && restart, out_valid && (element_number == '0))
    // the walk is finished while the final triangle is on display
    `GTIG_ASSERT_NOW(a_last_means_finished, clk, rst_n,
        out_valid && last_triangle, walk_reg.finished)

endmodule

`default_nettype wire
